// ===== src/adam_pkg.sv =====
// Package for the Adam parameter update block: widths, register indexes, state codes.
// Used by adam_front, adam_back and adam_parameter_update; depends on nothing.
package adam_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW = 10;
  localparam int unsigned CfgW = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [16:0] PowerOne = 17'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    RegLearningRate = 2'd0,
    RegDecayFirst   = 2'd1,
    RegDecaySecond  = 2'd2,
    RegStabilizer   = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StRead,
    StMul,
    StMoment,
    StDivM,
    StDivV,
    StSqrt,
    StDivR,
    StScale,
    StOut
  } back_state_e;

  // One classified beat passed from the front part to the back part.
  typedef struct packed {
    logic signed [DataW-1:0] gradient;
    logic signed [DataW-1:0] param_value;
    logic [IdxW-1:0]         element_index;
    logic                    in_range;
    logic [16:0]             first_power;
    logic [16:0]             second_power;
  } job_t;

endpackage

// ===== src/adam_front.sv =====
// Front part: accepts input beats, advances decay powers and step count, classifies
// the index and pushes a job into a two-entry queue. Depends on adam_pkg.
module adam_front #(
  parameter int unsigned ELEMENTS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [adam_pkg::DataW-1:0] gradient_i,
  input  logic signed [adam_pkg::DataW-1:0] param_value_i,
  input  logic [adam_pkg::IdxW-1:0]       element_index_i,
  input  logic                            new_step_i,
  input  logic [15:0]                     decay_first_i,
  input  logic [15:0]                     decay_second_i,
  output logic                            job_valid_o,
  input  logic                            job_pop_i,
  output adam_pkg::job_t                  job_o
);

  adam_pkg::job_t job_q [2];
  logic           rd_ptr_q, wr_ptr_q;
  logic [1:0]     count_q;
  logic [16:0]    p1_q, p2_q, p1_n, p2_n;
  logic [31:0]    step_q;
  logic [32:0]    prod1, prod2;
  logic           push, pop;
  adam_pkg::job_t job_n;

  assign in_stall = (count_q == 2'd2);
  assign push = in_valid && !in_stall;
  assign pop = job_pop_i && (count_q != 2'd0);
  assign job_valid_o = (count_q != 2'd0);
  assign job_o = job_q[rd_ptr_q];

  assign prod1 = p1_q * decay_first_i;
  assign prod2 = p2_q * decay_second_i;
  assign p1_n = new_step_i ? prod1[32:16] : p1_q;
  assign p2_n = new_step_i ? prod2[32:16] : p2_q;

  always_comb begin
    job_n.gradient = gradient_i;
    job_n.param_value = param_value_i;
    job_n.element_index = element_index_i;
    job_n.in_range = ({22'd0, element_index_i} < 32'(ELEMENTS));
    job_n.first_power = p1_n;
    job_n.second_power = p2_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      count_q <= 2'd0;
      p1_q <= adam_pkg::PowerOne;
      p2_q <= adam_pkg::PowerOne;
      step_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
        p1_q <= p1_n;
        p2_q <= p2_n;
        if (new_step_i) step_q <= step_q + 32'd1;
      end
      if (pop) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) job_q[wr_ptr_q] <= job_n;
  end

endmodule

// ===== src/adam_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle over 64 bits.
// Depends on nothing.
module adam_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [33:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic [63:0] q_q;
  logic [34:0] rem_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [34:0] shifted;
  logic        fits;

  assign shifted = {rem_q[33:0], q_q[63]};
  assign fits = shifted >= {1'b0, divisor_i};
  assign quotient_o = q_q;
  assign done_o = busy_q && (cnt_q == 7'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= 7'd64;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q && cnt_q != 7'd0) begin
      rem_q <= fits ? shifted - {1'b0, divisor_i} : shifted;
      q_q <= {q_q[62:0], fits};
    end
  end

endmodule

// ===== src/adam_sqrt.sv =====
// Iterative integer square root of a 64-bit value, two radicand bits per cycle.
// Depends on nothing.
module adam_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] x_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [35:0] trial, cand;

  assign cand = {rem_q, x_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};
  assign root_o = root_q;
  assign done_o = busy_q && (cnt_q == 6'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= 6'd32;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= radicand_i;
      rem_q <= '0;
      root_q <= '0;
    end else if (busy_q && cnt_q != 6'd0) begin
      x_q <= {x_q[61:0], 2'b00};
      if (cand >= trial) begin
        rem_q <= 34'(cand - trial);
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q <= cand[33:0];
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

endmodule

// ===== src/adam_back.sv =====
// Back part: moment update, bias correction, root and scaling for one job at a time.
// Depends on adam_pkg, adam_divider and adam_sqrt.
module adam_back #(
  parameter int unsigned ELEMENTS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_valid_i,
  output logic                              job_pop_o,
  input  adam_pkg::job_t                    job_i,
  input  logic [23:0]                       learning_rate_i,
  input  logic [15:0]                       decay_first_i,
  input  logic [15:0]                       decay_second_i,
  input  logic [15:0]                       stabilizer_i,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [adam_pkg::DataW-1:0] updated_value_o,
  output logic [adam_pkg::IdxW-1:0]         out_index_o
);

  localparam int unsigned AddrW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

  adam_pkg::back_state_e state_q, state_d;

  logic [31:0] m_mem [ELEMENTS];
  logic [31:0] v_mem [ELEMENTS];
  logic [AddrW-1:0] clr_addr_q;
  logic        clr_busy_q;
  logic [31:0] m_rd_q, v_rd_q;
  logic [AddrW-1:0] addr;

  adam_pkg::job_t job_q;
  logic signed [48:0] pm1_q, pm2_q;
  logic [48:0] pv1_q;
  logic [63:0] gsq_q;
  logic [63:0] pv2_q;
  logic signed [31:0] m_q;
  logic [31:0] v_q;
  logic [47:0] mhat_q;
  logic [33:0] den_q;
  logic [63:0] r_q;
  logic [63:0] dl_hi_q, dl_lo_q;
  logic signed [31:0] res_q;
  logic        out_valid_q;
  logic [9:0]  oidx_q;

  logic signed [32:0] g_abs_s;
  logic [31:0] g_abs;
  logic signed [64:0] msum;
  logic signed [64:0] mnew;
  logic [64:0] vsum;
  logic [63:0] vnew;
  logic [16:0] d1, d2;
  logic [31:0] m_abs;

  logic        div_start, div_done, sq_start, sq_done;
  logic [63:0] div_a, div_q;
  logic [33:0] div_b;
  logic [31:0] root;
  logic [34:0] delta;
  logic signed [35:0] sum;

  assign addr = AddrW'(job_q.element_index);
  assign g_abs_s = job_q.gradient[31] ? -{job_q.gradient[31], job_q.gradient}
                                       : {job_q.gradient[31], job_q.gradient};
  assign g_abs = g_abs_s[31:0];

  assign msum = 65'(pm1_q) + 65'(pm2_q) + 65'sd32768;
  assign mnew = msum >>> 16;
  assign vsum = 65'(pv1_q) + 65'(pv2_q) + 65'd32768;
  assign vnew = vsum[64:16] > 49'hFFFFFFFF ? 64'hFFFFFFFF : {15'd0, vsum[64:16]};

  assign d1 = (job_q.first_power >= adam_pkg::PowerOne) ? adam_pkg::PowerOne
              : adam_pkg::PowerOne - job_q.first_power;
  assign d2 = (job_q.second_power >= adam_pkg::PowerOne) ? adam_pkg::PowerOne
              : adam_pkg::PowerOne - job_q.second_power;
  assign m_abs = m_q[31] ? 32'(-{1'b1, m_q}) : m_q;

  assign delta = (dl_hi_q + (dl_lo_q >> 24)) > 64'h4_0000_0000 ? 35'h4_0000_0000
                 : 35'(dl_hi_q + (dl_lo_q >> 24));
  assign sum = m_q[31] ? 36'(job_q.param_value) + 36'(delta)
                       : 36'(job_q.param_value) - 36'(delta);

  adam_divider u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .dividend_i(div_a),
    .divisor_i(div_b), .done_o(div_done), .quotient_o(div_q)
  );

  adam_sqrt u_sqrt (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(sq_start),
    .radicand_i({div_q[47:0], 16'd0}), .done_o(sq_done), .root_o(root)
  );

  always_comb begin
    state_d = state_q;
    job_pop_o = 1'b0;
    div_start = 1'b0;
    sq_start = 1'b0;
    div_a = '0;
    div_b = 34'd1;
    case (state_q)
      adam_pkg::StIdle: begin
        if (job_valid_i && !out_valid_q && !clr_busy_q) begin
          job_pop_o = 1'b1;
          state_d = adam_pkg::StRead;
        end
      end
      adam_pkg::StRead: state_d = job_q.in_range ? adam_pkg::StMul : adam_pkg::StOut;
      adam_pkg::StMul: state_d = adam_pkg::StMoment;
      adam_pkg::StMoment: begin
        state_d = adam_pkg::StDivM;
      end
      adam_pkg::StDivM: begin
        div_a = {16'd0, m_abs, 16'd0};
        div_b = {17'd0, d1};
        if (div_done) begin
          div_a = {16'd0, v_q, 16'd0};
          div_b = {17'd0, d2};
          div_start = 1'b1;
          state_d = adam_pkg::StDivV;
        end
      end
      adam_pkg::StDivV: begin
        div_b = {17'd0, d2};
        if (div_done) begin
          sq_start = 1'b1;
          state_d = adam_pkg::StSqrt;
        end
      end
      adam_pkg::StSqrt: begin
        if (sq_done) begin
          div_a = {mhat_q, 16'd0};
          div_b = {2'd0, root} + {18'd0, (stabilizer_i == 16'd0) ? 16'd1 : stabilizer_i};
          div_start = 1'b1;
          state_d = adam_pkg::StDivR;
        end
      end
      adam_pkg::StDivR: begin
        div_b = den_q;
        if (div_done) state_d = adam_pkg::StScale;
      end
      adam_pkg::StScale: state_d = adam_pkg::StOut;
      adam_pkg::StOut: state_d = adam_pkg::StIdle;
      default: state_d = adam_pkg::StIdle;
    endcase
    if (state_q == adam_pkg::StMoment) begin
      div_a = {16'd0, (mnew[64] ? 32'(-mnew) : mnew[31:0]), 16'd0};
      div_start = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= adam_pkg::StIdle;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
        if (clr_addr_q == AddrW'(ELEMENTS - 1)) clr_busy_q <= 1'b0;
      end
      if (state_q == adam_pkg::StOut) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      m_mem[clr_addr_q] <= '0;
      v_mem[clr_addr_q] <= '0;
    end else if (state_q == adam_pkg::StMoment) begin
      m_mem[addr] <= (mnew > 65'sd2147483647) ? 32'h7FFFFFFF
                     : (mnew < -65'sd2147483648) ? 32'h80000000 : mnew[31:0];
      v_mem[addr] <= vnew[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) job_q <= job_i;
    if (state_q == adam_pkg::StRead) begin
      m_rd_q <= m_mem[addr];
      v_rd_q <= v_mem[addr];
      gsq_q <= g_abs * g_abs;
    end
    if (state_q == adam_pkg::StMul) begin
      pm1_q <= $signed({1'b0, decay_first_i}) * $signed(m_rd_q);
      pm2_q <= $signed({1'b0, 17'(adam_pkg::PowerOne - {1'b0, decay_first_i})})
               * job_q.gradient;
      pv1_q <= decay_second_i * v_rd_q;
    end
    if (state_q == adam_pkg::StMoment) begin
      if (mnew > 65'sd2147483647) m_q <= 32'h7FFFFFFF;
      else if (mnew < -65'sd2147483648) m_q <= 32'h80000000;
      else m_q <= mnew[31:0];
      v_q <= vnew[31:0];
    end
    if (state_q == adam_pkg::StDivM && div_done) mhat_q <= div_q[47:0];
    if (div_start && state_q == adam_pkg::StSqrt) den_q <= div_b;
    if (state_q == adam_pkg::StDivR && div_done) r_q <= div_q;
    if (state_q == adam_pkg::StScale) begin
      dl_hi_q <= 64'(learning_rate_i) * 64'(r_q[63:24]);
      dl_lo_q <= 64'(learning_rate_i) * 64'(r_q[23:0]);
    end
    if (state_q == adam_pkg::StOut) begin
      oidx_q <= job_q.element_index;
      if (!job_q.in_range) res_q <= job_q.param_value;
      else if (sum > 36'sd2147483647) res_q <= 32'h7FFFFFFF;
      else if (sum < -36'sd2147483648) res_q <= 32'h80000000;
      else res_q <= sum[31:0];
    end
  end

  // The second moment product needs the registered square, one stage later.
  always_ff @(posedge clk_i) begin
    pv2_q <= 64'(17'(adam_pkg::PowerOne - {1'b0, decay_second_i})) * 64'(gsq_q[63:16]);
  end

  assign out_valid = out_valid_q;
  assign updated_value_o = res_q;
  assign out_index_o = oidx_q;

endmodule

// ===== src/adam_parameter_update.sv =====
// Top level of the Adam parameter update block.
// Holds the configuration registers and joins adam_front and adam_back.
//
// Input beats (gradient, parameter, index, new_step) enter on in_valid/in_stall;
// one result beat (updated value and index) leaves on out_valid/out_stall for
// every input beat, in order. The front part takes a beat whenever its
// two-entry queue has room, advancing the decay powers on new_step. The back
// part works one beat at a time: memory read, multiply, moment update, two
// divisions, a square root and a third division, then scaling, with one
// iterative divider shared by all three divisions. It takes no new beat until
// the last result has left the output register. A beat whose index lies
// beyond the memory skips the arithmetic and keeps its parameter value.
// The result sits in an output register; while the receiver stalls it holds,
// the back part waits and the queue fills, then in_stall rises.
// Reset sets both powers to one, the step count to zero and the registers to
// their documented values, then clears the moment memories one element per
// cycle (1024 elements by default); up to two beats queue meanwhile.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i.
module adam_parameter_update #(
  parameter int unsigned ELEMENTS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [adam_pkg::DataW-1:0] gradient_i,
  input  logic signed [adam_pkg::DataW-1:0] param_value_i,
  input  logic [adam_pkg::IdxW-1:0]         element_index_i,
  input  logic                              new_step_i,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [adam_pkg::DataW-1:0] updated_value_o,
  output logic [adam_pkg::IdxW-1:0]         out_index_o,
  input  logic                              cfg_we_i,
  input  logic [adam_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [adam_pkg::CfgW-1:0]         cfg_data_i
);

  logic [23:0] lr_q;
  logic [15:0] b1_q, b2_q, eps_q;
  logic           job_valid, job_pop;
  adam_pkg::job_t job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= 24'd16777;
      b1_q <= 16'd58982;
      b2_q <= 16'd65470;
      eps_q <= 16'd1;
    end else if (cfg_we_i) begin
      case (adam_pkg::reg_idx_e'(cfg_index_i))
        adam_pkg::RegLearningRate: lr_q <= cfg_data_i;
        adam_pkg::RegDecayFirst:   b1_q <= cfg_data_i[15:0];
        adam_pkg::RegDecaySecond:  b2_q <= cfg_data_i[15:0];
        adam_pkg::RegStabilizer:   eps_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  adam_front #(.ELEMENTS(ELEMENTS)) u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_valid), .in_stall(in_stall),
    .gradient_i(gradient_i), .param_value_i(param_value_i),
    .element_index_i(element_index_i), .new_step_i(new_step_i),
    .decay_first_i(b1_q), .decay_second_i(b2_q),
    .job_valid_o(job_valid), .job_pop_i(job_pop), .job_o(job)
  );

  adam_back #(.ELEMENTS(ELEMENTS)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .job_valid_i(job_valid), .job_pop_o(job_pop),
    .job_i(job), .learning_rate_i(lr_q), .decay_first_i(b1_q),
    .decay_second_i(b2_q), .stabilizer_i(eps_q), .out_valid(out_valid),
    .out_stall(out_stall), .updated_value_o(updated_value_o),
    .out_index_o(out_index_o)
  );

endmodule
